// ===== design/spta_pkg.sv =====
// shared types, codes and helpers for the segment/page translation block
// no dependencies
package spta_pkg;

  localparam int VA_W      = 28;
  localparam int SEG_W     = 9;
  localparam int PAGE_W    = 10;
  localparam int OFF_W     = 9;
  localparam int WORD_W    = 20;
  localparam int ADDR_W    = 19;
  localparam int FRAME_W   = 10;
  localparam int MAPW_W    = 32;
  localparam int MAPA_W    = 5;
  localparam int FRAMES_DEF = 1024;

  typedef enum logic [1:0] {
    OP_READ     = 2'd0,
    OP_WRITE    = 2'd1,
    OP_LOAD_SEG = 2'd2,
    OP_LOAD_PTE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FAULT    = 3'd1,
    ST_ERROR    = 3'd2,
    ST_OOM      = 3'd3,
    ST_LOADED   = 3'd4,
    ST_IGNORED  = 3'd5
  } status_e;

  typedef struct packed {
    logic              re;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] wdata;
  } pmem_req_t;

  typedef struct packed {
    logic              re;
    logic              we;
    logic [MAPA_W-1:0] addr;
    logic [MAPW_W-1:0] wdata;
  } fmap_req_t;

  // index of the lowest set bit, zero when none
  function automatic logic [MAPA_W-1:0] lowest_bit(input logic [MAPW_W-1:0] v);
    logic [MAPA_W-1:0] r;
    r = '0;
    for (int i = MAPW_W - 1; i >= 0; i--) begin
      if (v[i]) r = MAPA_W'(i);
    end
    return r;
  endfunction

endpackage

// ===== design/spta_if.sv =====
// valid/ready channel interfaces for request and result items
// depends on spta_pkg
interface spta_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    operation;
  logic [spta_pkg::VA_W-1:0]     virtual_address;
  logic [spta_pkg::SEG_W-1:0]    table_segment;
  logic [spta_pkg::PAGE_W-1:0]   table_page;
  logic signed [spta_pkg::WORD_W-1:0] entry_value;

  modport source (output valid, operation, virtual_address, table_segment, table_page,
                  entry_value, input ready);
  modport sink   (input valid, operation, virtual_address, table_segment, table_page,
                  entry_value, output ready);
endinterface

interface spta_out_if;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  status;
  logic [spta_pkg::ADDR_W-1:0] physical_address;

  modport source (output valid, status, physical_address, input ready);
  modport sink   (input valid, status, physical_address, output ready);
endinterface

// ===== design/spta_pmem.sv =====
// physical word memory, registered read, zero sweep after reset
// depends on spta_pkg
module spta_pmem (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  spta_pkg::pmem_req_t         req_i,
  output logic [spta_pkg::WORD_W-1:0] rdata_o,
  output logic                        busy_o
);
  import spta_pkg::*;

  localparam int DEPTH = 1 << ADDR_W;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [ADDR_W:0]   clr_q;
  logic [WORD_W-1:0] rdata_q;

  assign busy_o  = !clr_q[ADDR_W];
  assign rdata_o = rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (busy_o) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_o) begin
      mem[clr_q[ADDR_W-1:0]] <= '0;
    end else if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

endmodule

// ===== design/spta_fmap.sv =====
// free-frame bitmap memory, per-word valid bits give the reset contents
// depends on spta_pkg
module spta_fmap (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  spta_pkg::fmap_req_t         req_i,
  output logic [spta_pkg::MAPW_W-1:0] rdata_o
);
  import spta_pkg::*;

  localparam int DEPTH = 1 << MAPA_W;

  logic [MAPW_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid_q;
  logic [MAPW_W-1:0] rdata_q;
  logic [MAPW_W-1:0] rst_word;

  // frame 0 holds the segment table
  assign rst_word = (req_i.addr == '0) ? MAPW_W'(1) : '0;
  assign rdata_o  = rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.we) begin
      valid_q[req_i.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= valid_q[req_i.addr] ? mem[req_i.addr] : rst_word;
    end
  end

endmodule

// ===== design/segment_page_translate_alloc.sv =====
// top level: sequencer for segment/page translation and frame allocation
// depends on spta_pkg, spta_if, spta_pmem, spta_fmap
//
// usage
//   in_i carries one request item (operation, virtual address, load
//   indexes, entry value); out_o returns one result item per request:
//   status and physical address
//   one request is worked on at a time; every step is a read, a
//   read-modify-write or a write of the physical word memory or the
//   frame bitmap, both of which have a registered read
//   allocation scans the bitmap word by word (up to FRAMES/32 words,
//   twice on a new table); each frame that a load or an allocation
//   takes is marked by a read-modify-write of its bitmap word
//   after reset the physical memory is swept to zero, one word a cycle,
//   while in_i.ready stays low
//   a finished result waits in the output register; a stalled receiver
//   holds it there, and the next request is taken in the meantime and
//   held in its last step until the register frees
module segment_page_translate_alloc #(
  parameter int FRAMES = spta_pkg::FRAMES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  spta_in_if.sink   in_i,
  spta_out_if.source out_o
);
  import spta_pkg::*;

  // bitmap words that hold allocatable frames
  localparam int WORDS = (FRAMES + MAPW_W - 1) / MAPW_W;
  localparam logic [MAPA_W-1:0] LAST_W = MAPA_W'(WORDS - 1);
  localparam logic [FRAME_W:0]  FR_LIM = (FRAME_W + 1)'(FRAMES);

  typedef enum logic [3:0] {
    S_IDLE, S_SEG_RD, S_SEG_WT, S_PTE_RD, S_PTE_WT,
    S_SC_RD, S_SC_WT, S_MK_RD, S_MK_WT, S_WR_PTE, S_WR_SEG, S_FIN
  } state_e;

  state_e            state_q, ret_q;
  op_e               op_q;
  logic [VA_W-1:0]   va_q;
  logic [SEG_W-1:0]  ts_q;
  logic [PAGE_W-1:0] tp_q;
  logic [WORD_W-1:0] ev_q;
  logic [ADDR_W-1:0] eaddr_q;
  logic [FRAME_W-1:0] pf_q, pg_q, mf_q;
  logic              new_q, pair_q, carry_q, mset_q;
  logic [1:0]        mn_q;
  logic [MAPA_W-1:0] word_q;
  status_e           stat_q;
  logic [ADDR_W-1:0] pa_q;
  logic              ov_q;
  logic [2:0]        os_q;
  logic [ADDR_W-1:0] opa_q;

  pmem_req_t         pm_req;
  fmap_req_t         fm_req;
  logic [WORD_W-1:0] pm_rd;
  logic [MAPW_W-1:0] fm_rd;
  logic              pm_busy;

  spta_pmem u_pmem (.clk_i, .rst_ni, .req_i(pm_req), .rdata_o(pm_rd), .busy_o(pm_busy));
  spta_fmap u_fmap (.clk_i, .rst_ni, .req_i(fm_req), .rdata_o(fm_rd));

  // address fields
  logic [SEG_W-1:0]  seg;
  logic [PAGE_W-1:0] page;
  logic [OFF_W-1:0]  off;
  assign seg  = va_q[VA_W-1 -: SEG_W];
  assign page = va_q[OFF_W +: PAGE_W];
  assign off  = va_q[OFF_W-1:0];

  // table entry classes
  logic ent_m1, ent_pos, ent_zero;
  assign ent_m1   = &pm_rd;
  assign ent_zero = (pm_rd == '0);
  assign ent_pos  = !pm_rd[WORD_W-1] && !ent_zero;
  logic ev_pos;
  assign ev_pos = !ev_q[WORD_W-1] && (ev_q != '0);

  logic [ADDR_W-1:0] ent_plus_page, ent_plus_tp;
  assign ent_plus_page = pm_rd[ADDR_W-1:0] + ADDR_W'(page);
  assign ent_plus_tp   = pm_rd[ADDR_W-1:0] + ADDR_W'(tp_q);

  // bitmap scan: frames at or beyond FRAMES count as used
  logic [MAPW_W-1:0] beyond, free_w, pair_w;
  always_comb begin
    for (int b = 0; b < MAPW_W; b++) begin
      beyond[b] = ({1'b0, word_q, MAPA_W'(b)} >= FR_LIM);
    end
  end
  assign free_w = ~(fm_rd | beyond);
  assign pair_w = free_w & {1'b0, free_w[MAPW_W-1:1]};

  logic cross_hit;
  assign cross_hit = carry_q && free_w[0];

  // bit to set or clear in the word being marked
  logic [MAPW_W-1:0] mbit;
  assign mbit = MAPW_W'(1) << mf_q[MAPA_W-1:0];

  always_comb begin
    pm_req = '0;
    fm_req = '0;
    unique case (state_q)
      S_SEG_RD: begin
        if (op_q == OP_LOAD_SEG) begin
          pm_req.we    = 1'b1;
          pm_req.addr  = ADDR_W'(ts_q);
          pm_req.wdata = ev_q;
        end else begin
          pm_req.re   = 1'b1;
          pm_req.addr = (op_q == OP_LOAD_PTE) ? ADDR_W'(ts_q) : ADDR_W'(seg);
        end
      end
      S_SEG_WT: begin
        if (op_q == OP_LOAD_PTE && ent_pos) begin
          pm_req.we    = 1'b1;
          pm_req.addr  = ent_plus_tp;
          pm_req.wdata = ev_q;
        end
      end
      S_PTE_RD: begin
        pm_req.re   = 1'b1;
        pm_req.addr = eaddr_q;
      end
      S_WR_PTE: begin
        pm_req.we    = 1'b1;
        pm_req.addr  = eaddr_q;
        pm_req.wdata = {1'b0, pg_q, {OFF_W{1'b0}}};
      end
      S_WR_SEG: begin
        pm_req.we    = 1'b1;
        pm_req.addr  = ADDR_W'(seg);
        pm_req.wdata = {1'b0, pf_q, {OFF_W{1'b0}}};
      end
      S_SC_RD: begin
        fm_req.re   = 1'b1;
        fm_req.addr = word_q;
      end
      S_MK_RD: begin
        fm_req.re   = 1'b1;
        fm_req.addr = mf_q[FRAME_W-1 -: MAPA_W];
      end
      S_MK_WT: begin
        fm_req.we    = 1'b1;
        fm_req.addr  = mf_q[FRAME_W-1 -: MAPA_W];
        fm_req.wdata = mset_q ? (fm_rd | mbit) : (fm_rd & ~mbit);
      end
      default: ;
    endcase
  end

  assign in_i.ready = (state_q == S_IDLE) && !pm_busy;
  assign out_o.valid = ov_q;
  assign out_o.status = os_q;
  assign out_o.physical_address = opa_q;

  logic [FRAME_W-1:0] found_f;
  logic [ADDR_W-1:0]  ev_addr;
  assign ev_addr = ev_q[ADDR_W-1:0];

  // frame picked from the word under scan: a pair across the word edge wins
  always_comb begin
    if (pair_q) begin
      found_f = cross_hit ? ({word_q, {MAPA_W{1'b0}}} - 1'b1)
                          : {word_q, lowest_bit(pair_w)};
    end else begin
      found_f = {word_q, lowest_bit(free_w)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      ov_q    <= 1'b0;
      new_q   <= 1'b0;
      pair_q  <= 1'b0;
      carry_q <= 1'b0;
      mset_q  <= 1'b0;
      mn_q    <= '0;
      word_q  <= '0;
    end else begin
      if (state_q == S_FIN && (!ov_q || out_o.ready)) begin
        ov_q <= 1'b1;
      end else if (ov_q && out_o.ready) begin
        ov_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid && in_i.ready) begin
            op_q    <= op_e'(in_i.operation);
            va_q    <= in_i.virtual_address;
            ts_q    <= in_i.table_segment;
            tp_q    <= in_i.table_page;
            ev_q    <= in_i.entry_value;
            new_q   <= 1'b0;
            pa_q    <= '0;
            state_q <= S_SEG_RD;
          end
        end
        S_SEG_RD: begin
          if (op_q == OP_LOAD_SEG) begin
            stat_q <= ST_LOADED;
            if (ev_pos) begin
              // table spans two frames, three when not frame aligned
              mf_q    <= ev_addr[ADDR_W-1 -: FRAME_W];
              mn_q    <= (ev_addr[OFF_W-1:0] == '0) ? 2'd2 : 2'd3;
              mset_q  <= 1'b1;
              ret_q   <= S_FIN;
              state_q <= S_MK_RD;
            end else begin
              state_q <= S_FIN;
            end
          end else begin
            state_q <= S_SEG_WT;
          end
        end
        S_SEG_WT: begin
          priority case (op_q)
            OP_LOAD_PTE: begin
              if (ent_pos) begin
                stat_q <= ST_LOADED;
                if (ev_pos) begin
                  mf_q    <= ev_addr[ADDR_W-1 -: FRAME_W];
                  mn_q    <= 2'd1;
                  mset_q  <= 1'b1;
                  ret_q   <= S_FIN;
                  state_q <= S_MK_RD;
                end else begin
                  state_q <= S_FIN;
                end
              end else begin
                stat_q  <= ST_IGNORED;
                state_q <= S_FIN;
              end
            end
            OP_READ: begin
              eaddr_q <= ent_plus_page;
              if (ent_m1) begin
                stat_q  <= ST_FAULT;
                state_q <= S_FIN;
              end else if (!ent_pos) begin
                stat_q  <= ST_ERROR;
                state_q <= S_FIN;
              end else begin
                state_q <= S_PTE_RD;
              end
            end
            default: begin
              eaddr_q <= ent_plus_page;
              if (ent_m1) begin
                stat_q  <= ST_FAULT;
                state_q <= S_FIN;
              end else if (pm_rd[WORD_W-1]) begin
                stat_q  <= ST_ERROR;
                state_q <= S_FIN;
              end else if (ent_zero) begin
                // no table yet: find two adjacent free frames
                word_q  <= '0;
                carry_q <= 1'b0;
                pair_q  <= 1'b1;
                state_q <= S_SC_RD;
              end else begin
                state_q <= S_PTE_RD;
              end
            end
          endcase
        end
        S_PTE_RD: state_q <= S_PTE_WT;
        S_PTE_WT: begin
          pa_q <= pm_rd[ADDR_W-1:0] + ADDR_W'(off);
          if (ent_m1) begin
            stat_q  <= ST_FAULT;
            state_q <= S_FIN;
          end else if (ent_pos) begin
            stat_q  <= ST_OK;
            state_q <= S_FIN;
          end else if (op_q == OP_WRITE && ent_zero) begin
            word_q  <= '0;
            carry_q <= 1'b0;
            pair_q  <= 1'b0;
            state_q <= S_SC_RD;
          end else begin
            stat_q  <= ST_ERROR;
            state_q <= S_FIN;
          end
        end
        S_SC_RD: state_q <= S_SC_WT;
        S_SC_WT: begin
          if (pair_q && (cross_hit || pair_w != '0)) begin
            pf_q    <= found_f;
            new_q   <= 1'b1;
            eaddr_q <= {found_f, {OFF_W{1'b0}}} + ADDR_W'(page);
            mf_q    <= found_f;
            mn_q    <= 2'd2;
            mset_q  <= 1'b1;
            word_q  <= '0;
            carry_q <= 1'b0;
            pair_q  <= 1'b0;
            ret_q   <= S_SC_RD;
            state_q <= S_MK_RD;
          end else if (!pair_q && free_w != '0) begin
            pg_q    <= found_f;
            pa_q    <= {found_f, off};
            mf_q    <= found_f;
            mn_q    <= 2'd1;
            mset_q  <= 1'b1;
            ret_q   <= S_WR_PTE;
            state_q <= S_MK_RD;
          end else if (word_q == LAST_W) begin
            stat_q <= ST_OOM;
            pa_q   <= '0;
            if (new_q) begin
              // give back the table frames
              mf_q    <= pf_q;
              mn_q    <= 2'd2;
              mset_q  <= 1'b0;
              ret_q   <= S_FIN;
              state_q <= S_MK_RD;
            end else begin
              state_q <= S_FIN;
            end
          end else begin
            // top frame of this word may pair with bit 0 of the next
            carry_q <= free_w[MAPW_W-1];
            word_q  <= word_q + 1'b1;
            state_q <= S_SC_RD;
          end
        end
        S_MK_RD: state_q <= S_MK_WT;
        S_MK_WT: begin
          mf_q <= mf_q + 1'b1;
          mn_q <= mn_q - 1'b1;
          state_q <= (mn_q == 2'd1) ? ret_q : S_MK_RD;
        end
        S_WR_PTE: begin
          stat_q  <= ST_OK;
          state_q <= new_q ? S_WR_SEG : S_FIN;
        end
        S_WR_SEG: state_q <= S_FIN;
        S_FIN: begin
          if (!ov_q || out_o.ready) begin
            os_q    <= stat_q;
            opa_q   <= (stat_q == ST_OK) ? pa_q : '0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== bench/spta_checker.sv =====
`timescale 1ns / 100ps
// result checker for the segment/page translation block: mirrors the word memory
// and the frame bitmap, predicts each result and compares; depends on spta_pkg, spta_if
module spta_checker #(
  parameter int FRAMES = spta_pkg::FRAMES_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  spta_in_if   req_w,
  spta_out_if  res_w,
  output int   failures_o,
  output int   pending_o
);
  import spta_pkg::*;

  localparam logic [ADDR_W-1:0] AMASK = '1;

  typedef struct packed {
    status_e           st;
    logic [ADDR_W-1:0] pa;
  } xlate_t;

  logic [WORD_W-1:0] mem_mirror [int];
  bit                frame_busy [1024];
  xlate_t            xlate_q [$];

  function automatic logic [WORD_W-1:0] mem_rd(input logic [ADDR_W-1:0] a);
    return mem_mirror.exists(int'(a)) ? mem_mirror[int'(a)] : '0;
  endfunction

  function automatic bit busy(input int f);
    return (f >= FRAMES || f >= 1024) ? 1'b1 : frame_busy[f];
  endfunction

  function automatic bit first_free(output int f);
    for (int i = 0; i < FRAMES; i++)
      if (!busy(i)) begin
        f = i;
        return 1'b1;
      end
    return 1'b0;
  endfunction

  function automatic bit first_free_pair(output int f);
    for (int i = 0; i + 1 < FRAMES; i++)
      if (!busy(i) && !busy(i + 1)) begin
        f = i;
        return 1'b1;
      end
    return 1'b0;
  endfunction

  task automatic translate(input op_e op, input logic [VA_W-1:0] va,
                           input logic [SEG_W-1:0] ts, input logic [PAGE_W-1:0] tp,
                           input logic [WORD_W-1:0] ev);
    logic [SEG_W-1:0]  seg;
    logic [PAGE_W-1:0] page;
    logic [OFF_W-1:0]  off;
    logic [ADDR_W-1:0] base, ea, a;
    int                ste, pte, pf, pg, n;
    bit                fresh;
    xlate_t            r;
    seg = va[27:19];
    page = va[18:9];
    off = va[8:0];
    r.st = ST_ERROR;
    r.pa = '0;
    pf = 0;
    pg = 0;
    fresh = 1'b0;
    case (op)
      OP_READ: begin
        ste = $signed(mem_rd(ADDR_W'(seg)));
        if (ste == -1) r.st = ST_FAULT;
        else if (ste > 0) begin
          pte = $signed(mem_rd((ADDR_W'(ste) + ADDR_W'(page)) & AMASK));
          if (pte == -1) r.st = ST_FAULT;
          else if (pte > 0) begin
            r.st = ST_OK;
            r.pa = ADDR_W'(pte) + ADDR_W'(off);
          end
        end
      end
      OP_WRITE: begin
        ste = $signed(mem_rd(ADDR_W'(seg)));
        if (ste == -1) r.st = ST_FAULT;
        else if (ste >= 0) begin
          r.st = ST_OK;
          if (ste == 0) begin
            // new table: two adjacent free frames
            if (!first_free_pair(pf)) r.st = ST_OOM;
            else begin
              frame_busy[pf] = 1'b1;
              frame_busy[pf + 1] = 1'b1;
              fresh = 1'b1;
              base = ADDR_W'(pf * 512);
            end
          end else base = ADDR_W'(ste);
          if (r.st == ST_OK) begin
            ea = base + ADDR_W'(page);
            pte = fresh ? 0 : $signed(mem_rd(ea));
            if (pte == -1) r.st = ST_FAULT;
            else if (pte < -1) r.st = ST_ERROR;
            else begin
              if (pte == 0) begin
                if (!first_free(pg)) begin
                  // atomic: give the table frames back
                  if (fresh) begin
                    frame_busy[pf] = 1'b0;
                    frame_busy[pf + 1] = 1'b0;
                  end
                  r.st = ST_OOM;
                end else begin
                  frame_busy[pg] = 1'b1;
                  pte = pg * 512;
                  mem_mirror[int'(ea)] = WORD_W'(pte);
                end
              end
              if (r.st == ST_OK) begin
                if (fresh) mem_mirror[int'(seg)] = WORD_W'(base);
                r.pa = ADDR_W'(pte) + ADDR_W'(off);
              end
            end
          end
        end
      end
      OP_LOAD_SEG: begin
        mem_mirror[int'(ts)] = ev;
        if ($signed(ev) > 0) begin
          // table covers 2 frames, 3 when unaligned, wrapping at the top
          a = ev[ADDR_W-1:0];
          n = ((int'(a) & 511) + 1023) / 512 + 1;
          for (int k = 0; k < n; k++) frame_busy[(int'(a >> 9) + k) & 1023] = 1'b1;
        end
        r.st = ST_LOADED;
      end
      default: begin
        ste = $signed(mem_rd(ADDR_W'(ts)));
        if (ste > 0) begin
          mem_mirror[int'((ADDR_W'(ste) + ADDR_W'(tp)) & AMASK)] = ev;
          if ($signed(ev) > 0) frame_busy[int'(ev[ADDR_W-1:9])] = 1'b1;
          r.st = ST_LOADED;
        end else r.st = ST_IGNORED;
      end
    endcase
    xlate_q.push_back(r);
  endtask

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $time, what);
    failures_o++;
  endtask

  initial begin
    failures_o = 0;
    frame_busy[0] = 1'b1;
  end

  assign pending_o = xlate_q.size();

  always @(posedge clk_i) begin
    xlate_t e;
    if (rst_ni) begin
      // requests first: a result never leaves on the edge its request enters
      if (req_w.valid && req_w.ready)
        translate(op_e'(req_w.operation), req_w.virtual_address, req_w.table_segment,
                  req_w.table_page, req_w.entry_value);
      if (res_w.valid && res_w.ready) begin
        if (xlate_q.size() == 0) report("result item with nothing expected");
        else begin
          e = xlate_q.pop_front();
          if (res_w.status !== e.st)
            report($sformatf("status %0d, expected %0d", res_w.status, e.st));
          if (res_w.physical_address !== e.pa)
            report($sformatf("address %h, expected %h", res_w.physical_address, e.pa));
        end
      end
    end
  end
endmodule

// ===== bench/segment_page_translate_alloc_tb.sv =====
`timescale 1ns / 100ps
// top of the testbench for segment_page_translate_alloc: clock, reset, request stimulus
// and result back-pressure; depends on spta_pkg, spta_if, spta_checker and the block
module segment_page_translate_alloc_tb;
  import spta_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   failures, pending;
  int   tx_idle_pct = 20;   // sender gap chance, percent per item
  int   rx_idle_pct = 74;   // receiver stall chance, percent per cycle
  bit   hold_req = 1'b0;    // asks the receiver for one long hold-off
  logic [SEG_W-1:0]  seg_pool [8];
  logic [VA_W-1:0]   written_q [$];

  spta_in_if  in_if ();
  spta_out_if out_if ();

  segment_page_translate_alloc u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  spta_checker u_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_w      (in_if),
    .res_w      (out_if),
    .failures_o (failures),
    .pending_o  (pending)
  );

  always #10 clk_i = ~clk_i;

  // drive one request item and wait for its handshake; entered and left on a falling edge
  task automatic send(input op_e op, input logic [VA_W-1:0] va, input logic [SEG_W-1:0] ts,
                      input logic [PAGE_W-1:0] tp, input logic [WORD_W-1:0] ev);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid = 1'b1;
    in_if.operation = op;
    in_if.virtual_address = va;
    in_if.table_segment = ts;
    in_if.table_page = tp;
    in_if.entry_value = ev;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
    if (op == OP_WRITE) written_q.push_back(va);
    if (written_q.size() > 64) void'(written_q.pop_front());
  endtask

  // table entry value: not resident, absent, malformed or a positive address
  function automatic logic [WORD_W-1:0] pick_entry();
    int c;
    c = $urandom_range(99);
    if (c < 30) return '1;
    if (c < 40) return '0;
    if (c < 50) return WORD_W'($urandom) | 20'h80000;
    return {1'b0, 19'($urandom)};
  endfunction

  function automatic logic [SEG_W-1:0] pick_seg();
    return ($urandom_range(99) < 80) ? seg_pool[$urandom_range(7)] : SEG_W'($urandom);
  endfunction

  task automatic random_item();
    int c;
    logic [VA_W-1:0] va;
    c = $urandom_range(99);
    va = {pick_seg(), 10'($urandom), 9'($urandom)};
    if (c < 40) send(OP_WRITE, va, 9'($urandom), 10'($urandom), 20'($urandom));
    else if (c < 65) begin
      // mostly reread what was written, with a fresh offset
      if (written_q.size() > 0 && $urandom_range(99) < 60)
        va = {written_q[$urandom_range(written_q.size() - 1)][27:9], 9'($urandom)};
      send(OP_READ, va, 9'($urandom), 10'($urandom), 20'($urandom));
    end else if (c < 80)
      send(OP_LOAD_SEG, 28'($urandom), pick_seg(), 10'($urandom), pick_entry());
    else
      send(OP_LOAD_PTE, 28'($urandom), pick_seg(), 10'($urandom), pick_entry());
  endtask

  // result side: random stalls plus one long hold-off on request
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        repeat (600) begin
          out_if.ready = 1'b0;
          @(negedge clk_i);
        end
        hold_req = 1'b0;
      end
      out_if.ready = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // watchdog covering the clearing sweep plus about a thousand slow items
  initial begin
    #80_000_000;
    $display("FAIL segment_page_translate_alloc");
    $finish;
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.operation = OP_READ;
    in_if.virtual_address = '0;
    in_if.table_segment = '0;
    in_if.table_page = '0;
    in_if.entry_value = '0;
    seg_pool = '{9'd0, 9'd1, 9'd2, 9'd3, 9'd100, 9'd255, 9'd256, 9'd511};
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty table reads, allocation at the address extremes
    send(OP_READ, 28'h0000000, 9'd0, 10'd0, 20'd0);          // absent segment
    send(OP_WRITE, 28'hFFFFFFF, 9'd0, 10'd0, 20'd0);         // top segment, page, offset
    send(OP_READ, 28'hFFFFFFF, 9'd0, 10'd0, 20'd0);
    send(OP_WRITE, 28'h0000000, 9'd0, 10'd0, 20'd0);
    send(OP_READ, 28'h00001FF, 9'd0, 10'd0, 20'd0);
    send(OP_READ, 28'h0000200, 9'd0, 10'd0, 20'd0);          // page absent in fresh table
    // not resident and malformed segment entries
    send(OP_LOAD_SEG, '0, 9'd5, 10'd0, 20'hFFFFF);
    send(OP_READ, {9'd5, 19'd7}, 9'd0, 10'd0, 20'd0);
    send(OP_WRITE, {9'd5, 19'd7}, 9'd0, 10'd0, 20'd0);
    send(OP_LOAD_PTE, '0, 9'd5, 10'd1, 20'd4096);            // ignored: not resident
    send(OP_LOAD_SEG, '0, 9'd6, 10'd0, 20'h80000);
    send(OP_READ, {9'd6, 19'd0}, 9'd0, 10'd0, 20'd0);
    send(OP_WRITE, {9'd6, 19'd0}, 9'd0, 10'd0, 20'd0);
    send(OP_LOAD_PTE, '0, 9'd6, 10'd0, 20'd1);               // ignored: malformed
    send(OP_LOAD_PTE, '0, 9'd7, 10'd3, 20'd1);               // ignored: absent
    // unaligned table wrapping past the last frame, address wrap at 19 bits
    send(OP_LOAD_SEG, '0, 9'd8, 10'd0, 20'h7FF00);
    send(OP_LOAD_PTE, '0, 9'd8, 10'd1023, 20'h7FFFF);
    send(OP_READ, {9'd8, 10'd1023, 9'h1FF}, 9'd0, 10'd0, 20'd0);
    send(OP_LOAD_PTE, '0, 9'd8, 10'd4, 20'hFFFFF);           // page not resident
    send(OP_READ, {9'd8, 10'd4, 9'd0}, 9'd0, 10'd0, 20'd0);
    send(OP_WRITE, {9'd8, 10'd4, 9'd0}, 9'd0, 10'd0, 20'd0);
    send(OP_LOAD_PTE, '0, 9'd8, 10'd5, 20'hFFFF0);           // malformed page entry
    send(OP_WRITE, {9'd8, 10'd5, 9'd0}, 9'd0, 10'd0, 20'd0);
    send(OP_LOAD_SEG, '0, 9'd511, 10'd0, 20'd512);           // aligned table at frame 1

    // random: receiver stalls often first, then sender idles often, then neither but one long hold-off
    for (int n = 0; n < 1000; n++) begin
      if (n == 333) begin
        tx_idle_pct = 74;
        rx_idle_pct = 20;
      end
      if (n == 666) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req = 1'b1;  // sender keeps offering while results back up
      end
      random_item();
    end
    in_if.valid = 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (failures == 0) $display("PASS segment_page_translate_alloc");
    else $display("FAIL segment_page_translate_alloc");
    $finish;
  end
endmodule

// ===== segment_page_translate_alloc.f =====
design/spta_pkg.sv
design/spta_if.sv
design/spta_pmem.sv
design/spta_fmap.sv
design/segment_page_translate_alloc.sv
bench/spta_checker.sv
bench/segment_page_translate_alloc_tb.sv
